// ----- rtl/core/fwk_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the Fenwick table.
package fwk_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int VALUE_W     = 32;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int POS_W       = ADDR_W + 2;
    localparam int REG_W       = 11;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [REG_W-1:0] ENTRIES_RESET = REG_W'(1024);

    localparam logic REQ_UPDATE = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    localparam logic [PADDR_W-3:0] REG_ENTRIES = '0;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPD_RD,
        ST_UPD_WR,
        ST_QHI_RD,
        ST_QHI_ACC,
        ST_QLO_RD,
        ST_QLO_ACC
    } state_t;

    typedef struct packed {
        logic clr_wr;
        logic capture;
        logic rd;
        logic upd_wr;
        logic acc_add;
        logic acc_sub;
        logic load_lo;
        logic emit;
        logic emit_err;
    } ctl_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic pos_zero;
        logic pos_in_use;
        logic is_query;
        logic idx_in_use;
    } ctl_sts_t;

endpackage

// ----- rtl/core/fwk_datapath.sv -----
// Datapath: partial-sum memory, walk position, accumulator and result registers.
module fwk_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  fwk_pkg::ctl_cmd_t            cmd,
    input  logic [fwk_pkg::CNT_W-1:0]    limit,
    input  logic                         req_type,
    input  logic [fwk_pkg::ADDR_W-1:0]   index,
    input  logic [fwk_pkg::ADDR_W-1:0]   low_index,
    input  logic [fwk_pkg::VALUE_W-1:0]  delta,
    output fwk_pkg::ctl_sts_t            sts,
    output logic                         done,
    output logic [fwk_pkg::VALUE_W-1:0]  range_total,
    output logic                         index_error
);
    import fwk_pkg::*;

    logic [VALUE_W-1:0] mem [MAX_ENTRIES];

    logic [ADDR_W-1:0]  clr_addr_reg;
    logic [ADDR_W-1:0]  clr_addr_next;
    logic               done_reg;
    logic               done_next;
    logic [POS_W-1:0]   pos_reg;
    logic [ADDR_W-1:0]  lo_reg;
    logic [VALUE_W-1:0] delta_reg;
    logic [VALUE_W-1:0] acc_reg;
    logic [VALUE_W-1:0] rdata_reg;
    logic [VALUE_W-1:0] total_reg;
    logic               err_reg;

    logic [POS_W-1:0]   lsb;
    logic [POS_W-1:0]   pos_m1;
    logic [ADDR_W-1:0]  rd_addr;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;

    // Tree step: lowest set bit of the position; store slot p lives at address p-1
    assign lsb     = pos_reg & (~pos_reg + POS_W'(1));
    assign pos_m1  = pos_reg - POS_W'(1);
    assign rd_addr = pos_m1[ADDR_W-1:0];

    assign mem_we    = cmd.clr_wr | cmd.upd_wr;
    assign mem_waddr = cmd.clr_wr ? clr_addr_reg : rd_addr;
    assign mem_wdata = cmd.clr_wr ? '0 : rdata_reg + delta_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign clr_addr_next = cmd.clr_wr ? clr_addr_reg + ADDR_W'(1) : clr_addr_reg;
    assign done_next     = cmd.emit | cmd.emit_err;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pos_reg   <= POS_W'(index) + POS_W'(1);
            lo_reg    <= low_index;
            delta_reg <= delta;
            acc_reg   <= '0;
        end
        else if (cmd.load_lo)
        begin
            pos_reg <= POS_W'(lo_reg);
        end
        else if (cmd.upd_wr)
        begin
            pos_reg <= pos_reg + lsb;
        end
        else if (cmd.acc_add)
        begin
            acc_reg <= acc_reg + rdata_reg;
            pos_reg <= pos_reg - lsb;
        end
        else if (cmd.acc_sub)
        begin
            acc_reg <= acc_reg - rdata_reg;
            pos_reg <= pos_reg - lsb;
        end

        if (cmd.emit_err)
        begin
            total_reg <= '0;
            err_reg   <= 1'b1;
        end
        else if (cmd.emit)
        begin
            total_reg <= acc_reg;
            err_reg   <= 1'b0;
        end
    end

    assign sts.clr_last   = (clr_addr_reg == ADDR_W'(MAX_ENTRIES - 1));
    assign sts.pos_zero   = (pos_reg == '0);
    assign sts.pos_in_use = (pos_reg <= POS_W'(limit));
    assign sts.is_query   = (req_type == REQ_QUERY);
    assign sts.idx_in_use = (CNT_W'(index) < limit);

    assign done        = done_reg;
    assign range_total = total_reg;
    assign index_error = err_reg;

endmodule

// ----- rtl/core/fwk_ctrl.sv -----
// Controller: sequences the clearing pass, update walks and the two prefix walks of a query.
module fwk_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  fwk_pkg::ctl_sts_t  sts,
    output fwk_pkg::ctl_cmd_t  cmd,
    output logic               busy
);
    import fwk_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    if (sts.is_query)
                    begin
                        if (sts.idx_in_use)
                        begin
                            state_next = ST_QHI_RD;
                        end
                        else
                        begin
                            cmd.emit_err = 1'b1;
                        end
                    end
                    else if (sts.idx_in_use)
                    begin
                        state_next = ST_UPD_RD;
                    end
                end
            end
            ST_UPD_RD:
            begin
                // stop once the walk climbs past the entries in use
                if (sts.pos_in_use)
                begin
                    cmd.rd     = 1'b1;
                    state_next = ST_UPD_WR;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_UPD_WR:
            begin
                cmd.upd_wr = 1'b1;
                state_next = ST_UPD_RD;
            end
            ST_QHI_RD:
            begin
                if (sts.pos_zero)
                begin
                    cmd.load_lo = 1'b1;
                    state_next  = ST_QLO_RD;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = ST_QHI_ACC;
                end
            end
            ST_QHI_ACC:
            begin
                cmd.acc_add = 1'b1;
                state_next  = ST_QHI_RD;
            end
            ST_QLO_RD:
            begin
                if (sts.pos_zero)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = ST_QLO_ACC;
                end
            end
            ST_QLO_ACC:
            begin
                cmd.acc_sub = 1'b1;
                state_next  = ST_QLO_RD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ----- rtl/core/fenwick_prefix_sum_table_core.sv -----
// Top level: Fenwick prefix-sum table with APB configuration, controller and datapath.
// Update: each tree step is a memory read, then a write back; up to 11 steps.
// Query: two walks, each step a memory read, then an accumulate; up to 10 steps each.
// An out-of-range query reports index_error with a zero total; an out-of-range update is dropped.
// Memory reads and writes take separate controller states; one item is in work at a time.
// After reset a clearing pass zeroes all 1024 memory entries with busy high.
module fenwick_prefix_sum_table_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          req_type,
    input  logic [fwk_pkg::ADDR_W-1:0]    index,
    input  logic [fwk_pkg::ADDR_W-1:0]    low_index,
    input  logic signed [fwk_pkg::VALUE_W-1:0] delta,
    output logic                          done,
    output logic signed [fwk_pkg::VALUE_W-1:0] range_total,
    output logic                          index_error,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fwk_pkg::PADDR_W-1:0]   paddr,
    input  logic [fwk_pkg::PDATA_W-1:0]   pwdata,
    output logic [fwk_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import fwk_pkg::*;

    logic [REG_W-1:0]   entries_reg;
    logic [REG_W-1:0]   entries_next;
    logic [CNT_W-1:0]   limit;
    logic               cfg_wr;
    logic               sel_entries;
    ctl_cmd_t           cmd;
    ctl_sts_t           sts;
    logic [VALUE_W-1:0] total;

    assign pready      = 1'b1;
    assign sel_entries = (paddr[PADDR_W-1:2] == REG_ENTRIES);
    assign cfg_wr      = psel & penable & pwrite & pready;

    assign entries_next = (cfg_wr && sel_entries) ? pwdata[REG_W-1:0] : entries_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg <= ENTRIES_RESET;
        end
        else
        begin
            entries_reg <= entries_next;
        end
    end

    assign prdata = sel_entries ? PDATA_W'(entries_reg) : '0;

    // clamp the register to the store size
    assign limit = (entries_reg > REG_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
                                                       : CNT_W'(entries_reg);

    fwk_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    fwk_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .limit       (limit),
        .req_type    (req_type),
        .index       (index),
        .low_index   (low_index),
        .delta       (delta),
        .sts         (sts),
        .done        (done),
        .range_total (total),
        .index_error (index_error)
    );

    assign range_total = total;

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && index_error |-> range_total == '0)
        else $error("error result with nonzero total");

    a_update_silent: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && req_type == REQ_UPDATE |=> !done)
        else $error("update item produced a result");

    a_query_range: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && req_type == REQ_QUERY && CNT_W'(index) >= limit
        |=> done && index_error)
        else $error("out-of-range query not flagged at once");

endmodule

// ----- verif/tb_fenwick_prefix_sum_table_core.sv -----
// Self-checking testbench for the Fenwick prefix-sum table core: directed and random items.
module tb_fenwick_prefix_sum_table_core;
    import fwk_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE_CYCLES = 60;
    localparam logic [PADDR_W-1:0] ENTRIES_ADDR = {REG_ENTRIES, 2'b00};

    typedef struct {
        logic signed [VALUE_W-1:0] total;
        logic                      err;
    } range_result_t;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic                      req_type;
    logic [ADDR_W-1:0]         index;
    logic [ADDR_W-1:0]         low_index;
    logic signed [VALUE_W-1:0] delta;
    logic                      done;
    logic signed [VALUE_W-1:0] range_total;
    logic                      index_error;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [PADDR_W-1:0]        paddr;
    logic [PDATA_W-1:0]        pwdata;
    logic [PDATA_W-1:0]        prdata;
    logic                      pready;

    // Predictor state: mirror of the partial-sum store and the register
    logic [VALUE_W-1:0] tree_sums [0:MAX_ENTRIES];
    logic [REG_W-1:0]   entries_reg;
    range_result_t      pending_totals [$];
    int                 errors;
    int                 cycles;

    fenwick_prefix_sum_table_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .index       (index),
        .low_index   (low_index),
        .delta       (delta),
        .done        (done),
        .range_total (range_total),
        .index_error (index_error),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t timeout after %0d cycles", $time, cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int unsigned limit_now();
        return (entries_reg > MAX_ENTRIES) ? MAX_ENTRIES : entries_reg;
    endfunction

    // Sum of positions 0..count-1, walking down by clearing the lowest set bit
    function automatic logic [VALUE_W-1:0] prefix_of(input int unsigned count);
        logic [VALUE_W-1:0] acc;
        int unsigned        pos;
        acc = '0;
        pos = count;
        while (pos > 0)
        begin
            if (pos <= MAX_ENTRIES)
                acc = acc + tree_sums[pos];
            pos = pos - (pos & (~pos + 1));
        end
        return acc;
    endfunction

    task automatic predict_item(input logic rt, input logic [ADDR_W-1:0] hi,
                                input logic [ADDR_W-1:0] lo, input logic [VALUE_W-1:0] d);
        int unsigned   lim;
        int unsigned   pos;
        range_result_t res;
        lim = limit_now();
        if (rt == REQ_UPDATE)
        begin
            if (hi < lim)
            begin
                pos = hi + 1;
                while (pos <= lim)
                begin
                    tree_sums[pos] = tree_sums[pos] + d;
                    pos = pos + (pos & (~pos + 1));
                end
            end
        end
        else
        begin
            if (hi >= lim)
            begin
                res.total = '0;
                res.err   = 1'b1;
            end
            else
            begin
                res.total = prefix_of(hi + 1) - prefix_of(lo);
                res.err   = 1'b0;
            end
            pending_totals.push_back(res);
        end
    endtask

    // Compare every result with the oldest expected range total
    always @(posedge clk)
    begin
        range_result_t exp_res;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (pending_totals.size() == 0)
            begin
                $display("%0t unexpected result: range_total %0d index_error %0b",
                         $time, range_total, index_error);
                errors = errors + 1;
            end
            else
            begin
                exp_res = pending_totals.pop_front();
                if (range_total !== exp_res.total)
                begin
                    $display("%0t range_total mismatch: expected %0d actual %0d",
                             $time, exp_res.total, range_total);
                    errors = errors + 1;
                end
                if (index_error !== exp_res.err)
                begin
                    $display("%0t index_error mismatch: expected %0b actual %0b",
                             $time, exp_res.err, index_error);
                    errors = errors + 1;
                end
            end
        end
    end

    // Leave start high on return so back-to-back items need no extra edge
    task automatic send_item(input logic rt, input logic [ADDR_W-1:0] hi,
                             input logic [ADDR_W-1:0] lo, input logic [VALUE_W-1:0] d);
        @(negedge clk);
        start     <= 1'b1;
        req_type  <= rt;
        index     <= hi;
        low_index <= lo;
        delta     <= d;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        predict_item(rt, hi, lo, d);
    endtask

    task automatic sender_gap();
        int unsigned pick;
        int unsigned len;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            len = 0;
        else if (pick < 90)
            len = $urandom_range(1, 3);
        else
            len = $urandom_range(10, 40);
        if (len > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (len - 1) @(negedge clk);
        end
    endtask

    task automatic send_then_idle(input logic rt, input logic [ADDR_W-1:0] hi,
                                  input logic [ADDR_W-1:0] lo, input logic [VALUE_W-1:0] d);
        send_item(rt, hi, lo, d);
        sender_gap();
    endtask

    // Drop start, wait for every range total, then let a trailing update finish
    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (pending_totals.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        if (addr == ENTRIES_ADDR)
            entries_reg = data[REG_W-1:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read_check(input logic [PADDR_W-1:0] addr,
                                  input logic [REG_W-1:0] exp_val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        if (prdata[REG_W-1:0] !== exp_val)
        begin
            $display("%0t entries_in_use readback mismatch: expected %0d actual %0d",
                     $time, exp_val, prdata[REG_W-1:0]);
            errors = errors + 1;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Upper data bits are random: only the low register bits count
    task automatic set_entries(input logic [REG_W-1:0] val);
        logic [PDATA_W-1:0] word;
        drain_results();
        word = $urandom;
        word[REG_W-1:0] = val;
        apb_write(ENTRIES_ADDR, word);
        apb_read_check(ENTRIES_ADDR, val);
    endtask

    task automatic test_register_reset();
        while (busy !== 1'b0)
            @(posedge clk);
        apb_read_check(ENTRIES_ADDR, ENTRIES_RESET);
    endtask

    task automatic test_empty_table();
        send_then_idle(REQ_QUERY, 10'd1023, 10'd0, $urandom);
        send_then_idle(REQ_QUERY, 10'd5, 10'd5, $urandom);
    endtask

    task automatic test_extreme_updates();
        send_then_idle(REQ_UPDATE, 10'd0, ADDR_W'($urandom), 32'h7FFF_FFFF);
        send_then_idle(REQ_UPDATE, 10'd1023, ADDR_W'($urandom), 32'h8000_0000);
        send_then_idle(REQ_UPDATE, 10'd511, ADDR_W'($urandom), 32'hFFFF_FFFF);
        send_then_idle(REQ_UPDATE, 10'd512, ADDR_W'($urandom), 32'd1);
        // Wrap position 0 past the positive maximum
        send_then_idle(REQ_UPDATE, 10'd0, ADDR_W'($urandom), 32'd1);
        send_then_idle(REQ_QUERY, 10'd1023, 10'd0, $urandom);
        send_then_idle(REQ_QUERY, 10'd0, 10'd0, $urandom);
        send_then_idle(REQ_QUERY, 10'd1023, 10'd1023, $urandom);
        send_then_idle(REQ_QUERY, 10'd512, 10'd511, $urandom);
        // Reversed ranges give the negated sum between the ends
        send_then_idle(REQ_QUERY, 10'd0, 10'd1023, $urandom);
        send_then_idle(REQ_QUERY, 10'd100, 10'd600, $urandom);
    endtask

    task automatic test_range_limits();
        set_entries(11'd5);
        send_then_idle(REQ_UPDATE, 10'd7, ADDR_W'($urandom), 32'd999);
        send_then_idle(REQ_UPDATE, 10'd4, ADDR_W'($urandom), 32'd100);
        send_then_idle(REQ_QUERY, 10'd7, 10'd0, $urandom);
        send_then_idle(REQ_QUERY, 10'd4, 10'd0, $urandom);
        send_then_idle(REQ_QUERY, 10'd4, 10'd1023, $urandom);
        set_entries(11'd0);
        send_then_idle(REQ_UPDATE, 10'd0, ADDR_W'($urandom), 32'd55);
        send_then_idle(REQ_QUERY, 10'd0, 10'd0, $urandom);
        // Above the store size: clamp, and the earlier sums must survive
        set_entries(11'd2047);
        send_then_idle(REQ_QUERY, 10'd1023, 10'd0, $urandom);
    endtask

    task automatic test_random_phases();
        logic [REG_W-1:0]   settings [10];
        int                 n_items;
        int unsigned        lim;
        logic               rt;
        logic [ADDR_W-1:0]  hi;
        logic [ADDR_W-1:0]  lo;
        logic [VALUE_W-1:0] d;
        bit                 quiet;
        settings = '{11'd1024, 11'd1, 11'd2, 11'd2047, 11'd0, 11'd16, 11'd1023,
                     11'd0, 11'd0, 11'd1024};
        settings[7] = REG_W'($urandom_range(3, 1022));
        settings[8] = REG_W'($urandom_range(3, 1022));
        for (int p = 0; p < 10; p++)
        begin
            set_entries(settings[p]);
            lim = limit_now();
            n_items = (lim <= 1) ? 60 : 200;
            quiet = 1'b0;
            for (int k = 0; k < n_items; k++)
            begin
                // Hold back-to-back stretches now and then
                if (k % 40 == 0)
                    quiet = ($urandom_range(0, 3) == 0);
                rt = 1'($urandom_range(0, 1));
                if (lim > 0 && $urandom_range(0, 99) < 85)
                    hi = ADDR_W'($urandom_range(0, lim - 1));
                else
                    hi = ADDR_W'($urandom);
                if ($urandom_range(0, 99) < 70)
                    lo = ADDR_W'($urandom_range(0, hi));
                else
                    lo = ADDR_W'($urandom);
                if ($urandom_range(0, 9) == 0)
                begin
                    case ($urandom_range(0, 3))
                        0: d = 32'h7FFF_FFFF;
                        1: d = 32'h8000_0000;
                        2: d = 32'hFFFF_FFFF;
                        default: d = 32'd0;
                    endcase
                end
                else
                    d = $urandom;
                send_item(rt, hi, lo, d);
                if ($urandom_range(0, 59) == 0)
                    drain_results();
                else if (!quiet)
                    sender_gap();
            end
        end
    endtask

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        req_type    = REQ_UPDATE;
        index       = '0;
        low_index   = '0;
        delta       = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        errors      = 0;
        cycles      = 0;
        entries_reg = ENTRIES_RESET;
        for (int i = 0; i <= MAX_ENTRIES; i++)
            tree_sums[i] = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_register_reset();
        test_empty_table();
        test_extreme_updates();
        test_range_limits();
        test_random_phases();

        drain_results();
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
